### hw/rtl/rkrf_pkg.sv
// rkrf_pkg: widths, codes, item and result types for the key repeat filter
// no dependencies; used by the interfaces, rkrf_filter and the top level
`default_nettype none

package rkrf_pkg;

  localparam int KEY_BITS       = 16;
  localparam int TIME_BITS      = 20;
  localparam int TMO_BITS       = TIME_BITS + 1;
  localparam int COUNT_BITS     = 8;
  localparam int CFG_BITS       = 16;
  localparam int CFG_INDEX_BITS = 1;
  localparam int OUT_DEPTH      = 4;
  localparam int OUT_PTR_BITS   = 2;
  localparam int OUT_CNT_BITS   = 3;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [CFG_BITS-1:0] REPEAT_DELAY_RESET    = 16'd300;
  localparam logic [CFG_BITS-1:0] REPEAT_INTERVAL_RESET = 16'd100;

  typedef enum logic {
    CMD_KEY  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_REPEAT_DELAY    = 1'b0,
    CFG_REPEAT_INTERVAL = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic                  cmd;
    logic [KEY_BITS-1:0]   key_code;
    logic [COUNT_BITS-1:0] repeat_count;
  } item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key_code_res;
    logic                is_repeat;
    logic                is_release;
    logic                last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } step_res_t;

  function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
    return (v == TIME_MAX) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/rkrf_if.sv
// rkrf_evt_if and rkrf_res_if: valid/ready channels for input items and results
// depends on rkrf_pkg
`default_nettype none

interface rkrf_evt_if import rkrf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [KEY_BITS-1:0]   key_code;
  logic [COUNT_BITS-1:0] repeat_count;

  modport source (output valid, cmd, key_code, repeat_count, input ready);
  modport sink (input valid, cmd, key_code, repeat_count, output ready);
endinterface

interface rkrf_res_if import rkrf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] key_code_res;
  logic                is_repeat;
  logic                is_release;
  logic                last;

  modport source (output valid, key_code_res, is_repeat, is_release, last, input ready);
  modport sink (input valid, key_code_res, is_repeat, is_release, last, output ready);
endinterface

`default_nettype wire

### hw/rtl/rkrf_filter.sv
// rkrf_filter: key state, elapsed counters, config registers and the per-item decision
// depends on rkrf_pkg
`default_nettype none

module rkrf_filter import rkrf_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]       cfg_data,
  input  wire logic                      step,
  input  wire item_t                     item,
  output step_res_t                      res
);

  logic [CFG_BITS-1:0]  repeat_delay;
  logic [CFG_BITS-1:0]  repeat_interval;

  logic [KEY_BITS-1:0]  held_key, held_key_next;
  logic                 held_valid, held_valid_next;
  logic                 key_pressed, key_pressed_next;
  logic                 key_repeating, key_repeating_next;
  logic [TIME_BITS-1:0] since_first_press, since_first_press_next;
  logic [TIME_BITS-1:0] since_last_emit, since_last_emit_next;
  logic [TIME_BITS-1:0] since_last_event, since_last_event_next;
  logic [TMO_BITS-1:0]  release_timeout, release_timeout_next;
  logic                 timeout_armed, timeout_armed_next;

  logic [TIME_BITS-1:0] sfp_inc, sle_inc, slv_inc;
  logic [TIME_BITS-1:0] delay_ext, interval_ext;
  logic [TMO_BITS:0]    tmo_sum;
  logic                 before_delay;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay    <= REPEAT_DELAY_RESET;
      repeat_interval <= REPEAT_INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_REPEAT_DELAY:    repeat_delay    <= cfg_data;
        CFG_REPEAT_INTERVAL: repeat_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sfp_inc      = sat_inc(since_first_press);
  assign sle_inc      = sat_inc(since_last_emit);
  assign slv_inc      = sat_inc(since_last_event);
  assign delay_ext    = {{(TIME_BITS-CFG_BITS){1'b0}}, repeat_delay};
  assign interval_ext = {{(TIME_BITS-CFG_BITS){1'b0}}, repeat_interval};
  // three times the gap before this event; dropping bit 0 gives three halves
  assign tmo_sum      = {2'b00, since_last_event} + {1'b0, since_last_event, 1'b0};
  assign before_delay = since_first_press < delay_ext;

  always_comb begin
    held_key_next          = held_key;
    held_valid_next        = held_valid;
    key_pressed_next       = key_pressed;
    key_repeating_next     = key_repeating;
    since_first_press_next = since_first_press;
    since_last_emit_next   = since_last_emit;
    since_last_event_next  = since_last_event;
    release_timeout_next   = release_timeout;
    timeout_armed_next     = timeout_armed;
    res                    = '0;

    if (item.cmd == CMD_TICK) begin
      since_first_press_next = sfp_inc;
      since_last_emit_next   = sle_inc;
      since_last_event_next  = slv_inc;
      if (timeout_armed && ({1'b0, slv_inc} >= release_timeout)) begin
        if (key_pressed && key_repeating) begin
          res.n     = 2'd1;
          res.first = '{key_code_res: held_key, is_repeat: 1'b0, is_release: 1'b1,
                        last: 1'b1};
        end
        key_pressed_next     = 1'b0;
        key_repeating_next   = 1'b0;
        held_valid_next      = 1'b0;
        held_key_next        = '0;
        timeout_armed_next   = 1'b0;
        release_timeout_next = '0;
      end
    end else begin
      since_last_event_next = '0;
      if (item.repeat_count == '0) begin
        if (!(held_valid && (item.key_code == held_key) && before_delay)) begin
          if (key_repeating) begin
            res.n      = 2'd2;
            res.first  = '{key_code_res: held_key, is_repeat: 1'b0, is_release: 1'b1,
                           last: 1'b0};
            res.second = '{key_code_res: item.key_code, is_repeat: 1'b0,
                           is_release: 1'b0, last: 1'b1};
          end else begin
            res.n     = 2'd1;
            res.first = '{key_code_res: item.key_code, is_repeat: 1'b0,
                          is_release: 1'b0, last: 1'b1};
          end
          held_key_next          = item.key_code;
          held_valid_next        = 1'b1;
          key_pressed_next       = 1'b1;
          key_repeating_next     = 1'b0;
          since_first_press_next = '0;
          timeout_armed_next     = 1'b0;
          release_timeout_next   = '0;
          since_last_emit_next   = '0;
        end
      end else if (!before_delay && !(since_last_emit < interval_ext)) begin
        res.n                = 2'd1;
        res.first            = '{key_code_res: item.key_code, is_repeat: 1'b1,
                                 is_release: 1'b0, last: 1'b1};
        key_pressed_next     = 1'b1;
        key_repeating_next   = 1'b1;
        release_timeout_next = tmo_sum[TMO_BITS:1];
        timeout_armed_next   = 1'b1;
        since_last_emit_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_key          <= '0;
      held_valid        <= 1'b0;
      key_pressed       <= 1'b0;
      key_repeating     <= 1'b0;
      since_first_press <= '0;
      since_last_emit   <= '0;
      since_last_event  <= '0;
      release_timeout   <= '0;
      timeout_armed     <= 1'b0;
    end else if (step) begin
      held_key          <= held_key_next;
      held_valid        <= held_valid_next;
      key_pressed       <= key_pressed_next;
      key_repeating     <= key_repeating_next;
      since_first_press <= since_first_press_next;
      since_last_emit   <= since_last_emit_next;
      since_last_event  <= since_last_event_next;
      release_timeout   <= release_timeout_next;
      timeout_armed     <= timeout_armed_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/remote_key_repeat_filter.sv
// remote_key_repeat_filter: top level, input register, result queue and assertions
// depends on rkrf_pkg, rkrf_if.sv and rkrf_filter
//
// evt carries key events (cmd 0, key_code, repeat_count) and one-millisecond
// ticks (cmd 1). res carries key press, repeat and release reports; last marks
// the final report caused by one input item. cfg_we/cfg_index/cfg_data write
// repeat_delay_ms (index 0) and repeat_interval_ms (index 1); the user must
// write them only while idle, as the block does not enforce it. An accepted
// item is held in the input register, evaluated once the queue has room for
// two reports, and its zero, one or two reports go into a four-entry queue.
// One item is taken per cycle while the queue has room for two reports, so
// the queue drain rate of one report per cycle while res.ready is high sets
// throughput: an item with two reports takes two transfers on the output channel.
// When res.ready is low the queue fills, evaluation holds once fewer than two
// entries are free, and evt.ready drops after the input register is full.
// Synchronous reset empties the queue and the input register, clears the key
// state and counters, and loads the register defaults 300 and 100.
`default_nettype none

module remote_key_repeat_filter import rkrf_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  rkrf_evt_if.sink                       evt,
  rkrf_res_if.source                     res,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]       cfg_data
);

  logic                    s1_valid;
  item_t                   s1_item;
  logic                    step;
  step_res_t               step_res;

  result_t                 queue [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0] wr_ptr;
  logic [OUT_PTR_BITS-1:0] rd_ptr;
  logic [OUT_CNT_BITS-1:0] count;
  logic [OUT_CNT_BITS-1:0] count_next;
  logic                    pop;
  logic [1:0]              push_n;

  assign step      = s1_valid && (count <= OUT_CNT_BITS'(OUT_DEPTH - 2));
  assign evt.ready = !s1_valid || step;
  assign push_n    = step ? step_res.n : 2'd0;
  assign pop       = res.valid && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt.ready) begin
      s1_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      s1_item <= '{cmd: evt.cmd, key_code: evt.key_code, repeat_count: evt.repeat_count};
    end
  end

  rkrf_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (s1_item),
    .res       (step_res)
  );

  // result queue
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= step_res.first;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + 1'b1] <= step_res.second;
    end
  end

  assign count_next = count + OUT_CNT_BITS'(push_n) - OUT_CNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUT_PTR_BITS'(push_n);
      rd_ptr <= rd_ptr + OUT_PTR_BITS'(pop);
      count  <= count_next;
    end
  end

  assign res.valid        = count != '0;
  assign res.key_code_res = queue[rd_ptr].key_code_res;
  assign res.is_repeat    = queue[rd_ptr].is_repeat;
  assign res.is_release   = queue[rd_ptr].is_release;
  assign res.last         = queue[rd_ptr].last;

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= OUT_CNT_BITS'(OUT_DEPTH))
    else $error("result queue overflow");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |=> res.valid)
    else $error("pushed report not presented");

  a_repeat_release: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.is_repeat && res.is_release))
    else $error("report marked both repeat and release");

  a_step_room: assert property (@(posedge clk) disable iff (rst)
    step |-> (count <= OUT_CNT_BITS'(OUT_DEPTH - 2)) && s1_valid)
    else $error("evaluation without queue room");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// tb_top: self-checking testbench for remote_key_repeat_filter
// drives key events and millisecond ticks, predicts every report and checks it
// depends on rkrf_pkg, the rkrf_evt_if/rkrf_res_if interfaces and the rtl top level

module tb_top;
  import rkrf_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]       cfg_data;

  rkrf_evt_if evt_ch();
  rkrf_res_if res_ch();

  remote_key_repeat_filter u_top (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted filter state
  logic [CFG_BITS-1:0]  delay_ms       = REPEAT_DELAY_RESET;
  logic [CFG_BITS-1:0]  interval_ms    = REPEAT_INTERVAL_RESET;
  logic [KEY_BITS-1:0]  held_code      = '0;
  logic                 held           = 1'b0;
  logic                 key_down       = 1'b0;
  logic                 key_auto       = 1'b0;
  logic [TIME_BITS-1:0] ms_since_press = '0;
  logic [TIME_BITS-1:0] ms_since_emit  = '0;
  logic [TIME_BITS-1:0] ms_since_event = '0;
  logic [TMO_BITS-1:0]  release_tmo    = '0;
  logic                 tmo_armed      = 1'b0;

  item_t   queued_events[$];
  result_t expected_reports[$];
  item_t   offered;
  result_t want;
  result_t got;

  int   queued_count  = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   mismatches    = 0;
  int   stall_cycles  = 0;
  int   hold_left     = 0;
  logic hold_req      = 1'b0;
  logic hold_taken    = 1'b0;

  function automatic logic [TIME_BITS-1:0] saturating_tick(input logic [TIME_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void predict_reports(input item_t it);
    result_t              reps[$];
    logic [TIME_BITS-1:0] gap;
    logic [TIME_BITS+1:0] scaled;
    if (it.cmd == CMD_TICK) begin
      ms_since_press = saturating_tick(ms_since_press);
      ms_since_emit  = saturating_tick(ms_since_emit);
      ms_since_event = saturating_tick(ms_since_event);
      if (tmo_armed && {1'b0, ms_since_event} >= release_tmo) begin
        if (key_down && key_auto) reps.push_back('{held_code, 1'b0, 1'b1, 1'b0});
        key_down    = 1'b0;
        key_auto    = 1'b0;
        held        = 1'b0;
        held_code   = '0;
        tmo_armed   = 1'b0;
        release_tmo = '0;
      end
    end else begin
      gap = ms_since_event;
      ms_since_event = '0;
      if (it.repeat_count == '0) begin
        // duplicate press of the held key inside the delay is dropped
        if (!(held && it.key_code == held_code && ms_since_press < delay_ms)) begin
          if (key_auto) reps.push_back('{held_code, 1'b0, 1'b1, 1'b0});
          held_code      = it.key_code;
          held           = 1'b1;
          key_down       = 1'b1;
          key_auto       = 1'b0;
          ms_since_press = '0;
          tmo_armed      = 1'b0;
          release_tmo    = '0;
          ms_since_emit  = '0;
          reps.push_back('{it.key_code, 1'b0, 1'b0, 1'b0});
        end
      end else if (ms_since_press >= delay_ms && ms_since_emit >= interval_ms) begin
        key_down      = 1'b1;
        key_auto      = 1'b1;
        scaled        = {2'b00, gap} + {1'b0, gap, 1'b0};
        release_tmo   = scaled[TMO_BITS:1];
        tmo_armed     = 1'b1;
        ms_since_emit = '0;
        reps.push_back('{it.key_code, 1'b1, 1'b0, 1'b0});
      end
    end
    if (reps.size() > 0) reps[reps.size()-1].last = 1'b1;
    foreach (reps[i]) expected_reports.push_back(reps[i]);
  endfunction

  task automatic queue_item(input cmd_t cmd, input logic [KEY_BITS-1:0] key,
                            input logic [COUNT_BITS-1:0] count);
    item_t it;
    it.cmd          = cmd;
    it.key_code     = key;
    it.repeat_count = count;
    queued_events.push_back(it);
    queued_count++;
  endtask

  task automatic queue_ticks(input int n);
    repeat (n) queue_item(CMD_TICK, KEY_BITS'($urandom), COUNT_BITS'($urandom));
  endtask

  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(5))
      0: return 16'h0001;
      1: return 16'h00A5;
      2: return 16'h7FFF;
      3: return 16'h8000;
      default: return KEY_BITS'($urandom);
    endcase
  endfunction

  // mostly press-then-repeat bursts with random spacing, some noise
  task automatic run_random(input int target);
    int                  stop;
    int                  span;
    int                  reps;
    logic [KEY_BITS-1:0] key;
    stop = queued_count + target;
    while (queued_count < stop) begin
      if ($urandom_range(9) == 0) begin
        queue_item(cmd_t'($urandom_range(1)), KEY_BITS'($urandom),
                   ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255)));
      end else begin
        span = (delay_ms + interval_ms) / 2 + 2;
        if (span > 8 && delay_ms > 100) span = 8;
        key  = pick_key();
        reps = $urandom_range(6);
        queue_item(CMD_KEY, key, 8'd0);
        repeat (reps) begin
          queue_ticks($urandom_range(span));
          case ($urandom_range(9))
            0: queue_item(CMD_KEY, key, 8'd0);
            1: queue_item(CMD_KEY, pick_key(), 8'($urandom_range(255, 1)));
            default: queue_item(CMD_KEY, key, 8'($urandom_range(255, 1)));
          endcase
        end
        queue_ticks($urandom_range(3 * span + 2));
      end
    end
  endtask

  task automatic write_config(input logic [CFG_BITS-1:0] delay,
                              input logic [CFG_BITS-1:0] interval);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_REPEAT_DELAY;
    cfg_data  <= delay;
    @(posedge clk);
    cfg_index <= CFG_REPEAT_INTERVAL;
    cfg_data  <= interval;
    @(posedge clk);
    cfg_we <= 1'b0;
    delay_ms    = delay;
    interval_ms = interval;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (queued_events.size() != 0 || evt_ch.valid || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // event driver
  always @(posedge clk) begin
    if (rst) begin
      evt_ch.valid <= 1'b0;
    end else begin
      if (evt_ch.valid && evt_ch.ready) predict_reports(offered);
      if (!evt_ch.valid || evt_ch.ready) begin
        if (queued_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = queued_events.pop_front();
          evt_ch.valid        <= 1'b1;
          evt_ch.cmd          <= offered.cmd;
          evt_ch.key_code     <= offered.key_code;
          evt_ch.repeat_count <= offered.repeat_count;
        end else begin
          evt_ch.valid <= 1'b0;
        end
      end
    end
  end

  // report monitor and receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_taken   <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.key_code_res, res_ch.is_repeat, res_ch.is_release, res_ch.last};
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected report: key %h rep %b rel %b last %b",
                     got.key_code_res, got.is_repeat, got.is_release, got.last);
        end else begin
          want = expected_reports.pop_front();
          if (got.key_code_res !== want.key_code_res || got.is_repeat !== want.is_repeat ||
              got.is_release !== want.is_release || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("report mismatch: expected %h %b %b %b, got %h %b %b %b",
                       want.key_code_res, want.is_repeat, want.is_release, want.last,
                       got.key_code_res, got.is_repeat, got.is_release, got.last);
          end
        end
      end
      if (hold_req && !hold_taken) begin
        hold_taken   <= 1'b1;
        hold_left    <= HOLD_CYCLES;
        res_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = CFG_REPEAT_DELAY;
    cfg_data            = '0;
    evt_ch.valid        = 1'b0;
    evt_ch.cmd          = CMD_KEY;
    evt_ch.key_code     = '0;
    evt_ch.repeat_count = '0;
    res_ch.ready        = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 11;
    recv_idle_pct = 50;
    write_config(16'd4, 16'd2);
    queue_item(CMD_KEY, 16'hFFFF, 8'd0);
    queue_item(CMD_KEY, 16'hFFFF, 8'd0);
    queue_ticks(2);
    queue_item(CMD_KEY, 16'hFFFF, 8'd1);
    queue_ticks(2);
    queue_item(CMD_KEY, 16'hFFFF, 8'd255);
    queue_ticks(2);
    // repeat of another key, then one dropped by the interval
    queue_item(CMD_KEY, 16'h0000, 8'd128);
    queue_item(CMD_KEY, 16'h0000, 8'd1);
    // new press while repeating: release of the held key first
    queue_item(CMD_KEY, 16'h1234, 8'd0);
    queue_ticks(4);
    queue_item(CMD_KEY, 16'h1234, 8'd1);
    queue_ticks(7);
    wait_idle();

    write_config(16'($urandom_range(12)), 16'($urandom_range(6)));
    run_random(220);
    hold_req <= 1'b1;
    wait_idle();

    send_idle_pct = 50;
    recv_idle_pct = 11;
    write_config(16'hFFFF, 16'hFFFF);
    run_random(80);
    wait_idle();
    write_config(16'($urandom_range(12)), 16'($urandom_range(6)));
    run_random(150);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_config(16'd0, 16'd0);
    // a repeat right after its press gives a zero timeout
    queue_item(CMD_KEY, 16'h00A5, 8'd0);
    queue_item(CMD_KEY, 16'h00A5, 8'd200);
    queue_ticks(1);
    queue_item(CMD_KEY, 16'h5A5A, 8'd0);
    queue_item(CMD_KEY, 16'h5A5A, 8'd0);
    run_random(150);
    wait_idle();

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
